[hw/rtl/ovl_pkg.sv]
// Shared types, constants and helpers for the ordered value list engine.
package ovl_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Port field widths, fixed by the request/response format
    localparam int MODE_FW   = 3;
    localparam int DATA_FW   = 32;
    localparam int STATUS_FW = 2;
    localparam int POS_FW    = 4;
    localparam int COUNT_FW  = 5;

    typedef logic [VALUE_WIDTH-1:0] t_val;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;

    typedef enum logic [2:0] {
        MODE_INS_HEAD  = 3'd0,
        MODE_INS_TAIL  = 3'd1,
        MODE_INS_AFTER = 3'd2,
        MODE_DEL_HEAD  = 3'd3,
        MODE_DEL_TAIL  = 3'd4,
        MODE_DEL_VALUE = 3'd5,
        MODE_SEARCH    = 3'd6,
        MODE_COUNT     = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    // Broadcast to every cell in the update cycle
    typedef struct packed {
        t_cell_op op;
        t_idx     pos;
        t_val     value;
    } t_cell_cmd;

    // First-match scan passed from head toward tail
    typedef struct packed {
        logic hit_any;
        t_idx pos;
        logic tail_hit;
    } t_scan;

    // Sign-extend (or truncate) a 32-bit request field to the stored width
    function automatic t_val to_value(input logic [DATA_FW-1:0] raw);
        return VALUE_WIDTH'(signed'(raw));
    endfunction

endpackage

[hw/rtl/ovl_req_if.sv]
// Request channel: mode, value and anchor with valid/ready.
interface ovl_req_if;
    logic                               valid;
    logic                               ready;
    logic [ovl_pkg::MODE_FW-1:0]        mode;
    logic signed [ovl_pkg::DATA_FW-1:0] value;
    logic signed [ovl_pkg::DATA_FW-1:0] anchor;

    modport source (output valid, output mode, output value, output anchor, input ready);
    modport sink   (input valid, input mode, input value, input anchor, output ready);
endinterface

[hw/rtl/ovl_rsp_if.sv]
// Response channel: status, found, position and entry count with valid/ready.
interface ovl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ovl_pkg::STATUS_FW-1:0] status;
    logic                          found;
    logic [ovl_pkg::POS_FW-1:0]    position;
    logic [ovl_pkg::COUNT_FW-1:0]  entry_count;

    modport source (output valid, output status, output found, output position,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input entry_count, output ready);
endinterface

[hw/rtl/ordered_value_list_engine.sv]
// Ordered value list engine: top level with request sequencer and response register.
//
// Keeps an ordered list of up to CAPACITY values (head at position 0) in a row
// of cells, one slot per cell. Each request beat carries one operation: insert
// at head/tail, insert after an anchor, delete head/tail, delete the first
// match of a value, search, or count; each yields exactly one response beat
// with status, found flag, match position and the entry count afterwards.
// Sequence: an accepted request passes through S_CMP, in which every cell
// compares its slot against the key in parallel, and then S_EXEC, in which the
// first-match scan runs down the row, all cells shift or load together and the
// response is loaded into the output register. A new request is taken in the
// same cycle as the previous one retires, never earlier; a stalled
// response holds the engine in its update cycle. There is no clearing pass:
// after reset the list is empty and slot contents are never read until written.
module ordered_value_list_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ovl_req_if.sink   i_req,
    ovl_rsp_if.source o_rsp
);
    import ovl_pkg::*;

    t_state    r_state, n_state;
    t_cnt      r_occ, n_occ;
    t_mode     r_mode;
    t_val      r_value;
    t_val      r_key;

    // response register
    logic      r_rsp_valid;
    t_status   r_status, n_status;
    logic      r_found, n_found;
    t_idx      r_pos, n_pos;

    t_cell_cmd cell_cmd;
    t_scan     scan;
    logic      req_fire;
    logic      out_free;
    logic      exec_done;
    logic      full;
    logic      empty;
    t_idx      tail_idx;

    assign out_free  = !r_rsp_valid || o_rsp.ready;
    assign exec_done = (r_state == S_EXEC) && out_free;
    assign req_fire  = i_req.valid && i_req.ready;
    assign full      = r_occ == CNT_W'(CAPACITY);
    assign empty     = r_occ == '0;
    assign tail_idx  = IDX_W'(r_occ - CNT_W'(1));

    ovl_chain u_chain (
        .i_clk    (i_clk),
        .i_occ    (r_occ),
        .i_cmp_en (r_state == S_CMP),
        .i_key    (r_key),
        .i_cmd    (cell_cmd),
        .o_scan   (scan)
    );

    // ---- sequencer: next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req_fire) n_state = S_CMP;
            S_CMP:  n_state = S_EXEC;
            S_EXEC: begin
                if (exec_done) n_state = req_fire ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    // a new request may enter while the previous one retires
    always_comb begin
        i_req.ready = (r_state == S_IDLE) || exec_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture request; the compare key is the anchor for insert-after
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_mode  <= t_mode'(i_req.mode);
            r_value <= to_value(i_req.value);
            r_key   <= (t_mode'(i_req.mode) == MODE_INS_AFTER) ? to_value(i_req.anchor)
                                                                : to_value(i_req.value);
        end
    end

    // ---- operation decode in the update cycle ----
    always_comb begin
        n_status       = ST_OK;
        n_found        = 1'b0;
        n_pos          = '0;
        n_occ          = r_occ;
        cell_cmd.op    = CELL_HOLD;
        cell_cmd.pos   = '0;
        cell_cmd.value = r_value;

        unique case (r_mode)
            MODE_INS_HEAD: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cell_cmd.op = CELL_INSERT;
                    n_occ       = r_occ + CNT_W'(1);
                end
            end
            MODE_INS_TAIL: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cell_cmd.op  = CELL_INSERT;
                    cell_cmd.pos = IDX_W'(r_occ);
                    n_occ        = r_occ + CNT_W'(1);
                end
            end
            MODE_INS_AFTER: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (empty) begin
                    n_status = ST_EMPTY;
                end else if (scan.tail_hit) begin
                    // tail matched: append, report the tail position
                    n_found      = 1'b1;
                    n_pos        = tail_idx;
                    cell_cmd.op  = CELL_INSERT;
                    cell_cmd.pos = IDX_W'(r_occ);
                    n_occ        = r_occ + CNT_W'(1);
                end else if (scan.hit_any) begin
                    n_found      = 1'b1;
                    n_pos        = scan.pos;
                    cell_cmd.op  = CELL_INSERT;
                    cell_cmd.pos = scan.pos + IDX_W'(1);
                    n_occ        = r_occ + CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_DEL_HEAD: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    cell_cmd.op = CELL_REMOVE;
                    n_occ       = r_occ - CNT_W'(1);
                end
            end
            MODE_DEL_TAIL: begin
                // tail slot is simply dropped from the count
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_occ = r_occ - CNT_W'(1);
                end
            end
            MODE_DEL_VALUE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (scan.hit_any) begin
                    n_found      = 1'b1;
                    n_pos        = scan.pos;
                    cell_cmd.op  = CELL_REMOVE;
                    cell_cmd.pos = scan.pos;
                    n_occ        = r_occ - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_SEARCH: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (scan.hit_any) begin
                    n_found = 1'b1;
                    n_pos   = scan.pos;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                // count: report only
            end
        endcase

        // only commit when the response register can take the result
        if (!exec_done) begin
            cell_cmd.op = CELL_HOLD;
            n_occ       = r_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (exec_done) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_pos    <= n_pos;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.found       = r_found;
    assign o_rsp.position    = POS_FW'(r_pos);
    assign o_rsp.entry_count = COUNT_FW'(r_occ);

endmodule

[hw/rtl/ovl_cell.sv]
// One list slot: holds a value, compares it to the key, shifts with its neighbors.
module ovl_cell (
    input  logic               i_clk,
    input  ovl_pkg::t_idx      i_index,
    input  ovl_pkg::t_cnt      i_occ,
    input  logic               i_cmp_en,
    input  ovl_pkg::t_val      i_key,
    input  ovl_pkg::t_cell_cmd i_cmd,
    input  ovl_pkg::t_val      i_left,
    input  ovl_pkg::t_val      i_right,
    input  ovl_pkg::t_scan     i_scan,
    output ovl_pkg::t_scan     o_scan,
    output ovl_pkg::t_val      o_value
);
    import ovl_pkg::*;

    t_val r_value;
    logic r_hit;
    logic r_tail;
    logic in_list;
    logic is_tail;

    assign in_list = CNT_W'(i_index) < i_occ;
    assign is_tail = (CNT_W'(i_index) + CNT_W'(1)) == i_occ;

    // match flags, registered at the compare and held until the next compare
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_hit  <= (r_value == i_key) && in_list;
            r_tail <= (r_value == i_key) && is_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CELL_INSERT: begin
                if (i_index > i_cmd.pos) begin
                    r_value <= i_left;
                end else if (i_index == i_cmd.pos) begin
                    r_value <= i_cmd.value;
                end
            end
            CELL_REMOVE: begin
                if (i_index >= i_cmd.pos) begin
                    r_value <= i_right;
                end
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

    always_comb begin
        o_scan.hit_any  = i_scan.hit_any | r_hit;
        o_scan.pos      = (!i_scan.hit_any && r_hit) ? i_index : i_scan.pos;
        o_scan.tail_hit = i_scan.tail_hit | r_tail;
    end

    assign o_value = r_value;

endmodule

[hw/rtl/ovl_chain.sv]
// Row of list cells, head at index 0, with neighbor shift and scan wiring.
module ovl_chain (
    input  logic               i_clk,
    input  ovl_pkg::t_cnt      i_occ,
    input  logic               i_cmp_en,
    input  ovl_pkg::t_val      i_key,
    input  ovl_pkg::t_cell_cmd i_cmd,
    output ovl_pkg::t_scan     o_scan
);
    import ovl_pkg::*;

    t_val  cell_val  [CAPACITY];
    t_scan scan_link [CAPACITY+1];

    assign scan_link[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_val left_val;
        t_val right_val;

        if (g == 0) begin : g_head
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        ovl_cell u_cell (
            .i_clk    (i_clk),
            .i_index  (IDX_W'(g)),
            .i_occ    (i_occ),
            .i_cmp_en (i_cmp_en),
            .i_key    (i_key),
            .i_cmd    (i_cmd),
            .i_left   (left_val),
            .i_right  (right_val),
            .i_scan   (scan_link[g]),
            .o_scan   (scan_link[g+1]),
            .o_value  (cell_val[g])
        );
    end

    assign o_scan = scan_link[CAPACITY];

endmodule

[sim/tb_ordered_value_list_engine.sv]
// Self-checking testbench for the ordered value list engine: directed and random list traffic.
module tb_ordered_value_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ovl_pkg::*;

    localparam int TOTAL_ITEMS  = 1150;    // request beats queued for the run
    localparam int CALM_ITEMS   = 120;     // tail of the run with no idling on either side
    localparam int HOLD_AT      = 300;     // request beat count that triggers the long stall
    localparam int HOLD_CYCLES  = 300;     // length of the long response stall
    localparam int DRAIN_CYCLES = 8;       // settle time after the last reply
    localparam int CYCLE_LIMIT  = 200000;

    localparam t_val VMIN = 32'h8000_0000;
    localparam t_val VMAX = 32'h7fff_ffff;

    typedef struct {
        t_mode mode;
        t_val  value;
        t_val  anchor;
        bit    drain_first;    // hold this beat until every reply is back
    } list_request_t;

    typedef struct {
        t_status               status;
        logic                  found;
        logic [POS_FW-1:0]     position;
        logic [COUNT_FW-1:0]   entry_count;
    } list_reply_t;

    logic i_clk;
    logic i_rst_n;

    ovl_req_if req_bus ();
    ovl_rsp_if rsp_bus ();

    ordered_value_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    list_request_t request_q[$];    // beats waiting to be offered
    list_reply_t   reply_q[$];      // replies owed by the engine, oldest first
    t_val          list_image[$];   // head at index 0, tail at the back
    t_val          common_vals[8];  // small pool so lookups hit often

    list_request_t next_req;
    list_reply_t   want;
    int            gap_left;
    int            stall_left;
    int            req_beats  = 0;
    int            hold_left  = 0;
    bit            hold_fired = 1'b0;
    bit            calm       = 1'b0;
    int            mismatches = 0;
    int            cycles     = 0;

    // Index of the first entry equal to key, -1 when absent.
    function automatic int index_of(t_val key);
        for (int i = 0; i < list_image.size(); i++) begin
            if (list_image[i] == key) return i;
        end
        return -1;
    endfunction

    // Apply one operation to the list image and return the reply it must produce.
    function automatic list_reply_t apply_request(t_mode mode, t_val v, t_val a);
        list_reply_t r;
        int          hit;
        bit          full;
        bit          empty;
        r.status   = ST_OK;
        r.found    = 1'b0;
        r.position = '0;
        full  = list_image.size() >= CAPACITY;
        empty = list_image.size() == 0;
        case (mode)
            MODE_INS_HEAD: begin
                if (full) r.status = ST_FULL;
                else list_image.push_front(v);
            end
            MODE_INS_TAIL: begin
                if (full) r.status = ST_FULL;
                else list_image.push_back(v);
            end
            MODE_INS_AFTER: begin
                if (full) begin
                    r.status = ST_FULL;
                end else if (empty) begin
                    r.status = ST_EMPTY;
                end else if (list_image[list_image.size()-1] == a) begin
                    // tail match wins over an earlier one
                    r.found    = 1'b1;
                    r.position = POS_FW'(list_image.size() - 1);
                    list_image.push_back(v);
                end else begin
                    hit = index_of(a);
                    if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.found    = 1'b1;
                        r.position = POS_FW'(hit);
                        list_image.insert(hit + 1, v);
                    end
                end
            end
            MODE_DEL_HEAD: begin
                if (empty) r.status = ST_EMPTY;
                else void'(list_image.pop_front());
            end
            MODE_DEL_TAIL: begin
                if (empty) r.status = ST_EMPTY;
                else void'(list_image.pop_back());
            end
            MODE_DEL_VALUE, MODE_SEARCH: begin
                hit = index_of(v);
                if (empty) begin
                    r.status = ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found    = 1'b1;
                    r.position = POS_FW'(hit);
                    if (mode == MODE_DEL_VALUE) list_image.delete(hit);
                end
            end
            default: ;    // count leaves the list alone
        endcase
        r.entry_count = COUNT_FW'(list_image.size());
        return r;
    endfunction

    function automatic t_val pick_value();
        if ($urandom_range(0, 4) == 0) return t_val'($urandom);
        return common_vals[$urandom_range(0, 7)];
    endfunction

    task automatic queue_item(t_mode m, t_val v, t_val a, bit drain = 1'b0);
        list_request_t it;
        it.mode        = m;
        it.value       = v;
        it.anchor      = a;
        it.drain_first = drain;
        request_q.push_back(it);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Request driver: one beat offered at a time, held until the engine takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            req_beats     <= 0;
            gap_left = 0;
        end else if (!req_bus.valid || req_bus.ready) begin
            if (req_bus.valid) begin
                reply_q.push_back(apply_request(t_mode'(req_bus.mode), t_val'(req_bus.value),
                                                t_val'(req_bus.anchor)));
                req_beats <= req_beats + 1;
            end
            if (gap_left != 0) begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end else if (request_q.size() == 0 ||
                         (request_q[0].drain_first && reply_q.size() != 0)) begin
                req_bus.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 15);
                req_bus.valid <= 1'b0;
            end else begin
                next_req = request_q.pop_front();
                req_bus.valid  <= 1'b1;
                req_bus.mode   <= next_req.mode;
                req_bus.value  <= next_req.value;
                req_bus.anchor <= next_req.anchor;
                calm <= (request_q.size() < CALM_ITEMS);
            end
        end
    end

    // One long response stall, so the engine fills up and backs up the request side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && req_beats >= HOLD_AT) begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Reply monitor: checks every accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (reply_q.size() == 0) begin
                    $error("reply beat with nothing outstanding: status %0d count %0d",
                           rsp_bus.status, rsp_bus.entry_count);
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                        mismatches++;
                    end
                    if (rsp_bus.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
                        mismatches++;
                    end
                    if (rsp_bus.position !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               want.position, rsp_bus.position);
                        mismatches++;
                    end
                    if (rsp_bus.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, rsp_bus.entry_count);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0) begin
                rsp_bus.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int    kind;
        int    n;
        t_mode m;
        bit    first_drain;

        i_rst_n = 1'b0;

        common_vals = '{VMIN, VMAX, 32'd0, 32'hffff_ffff, 32'd1,
                        t_val'($urandom), t_val'($urandom), t_val'($urandom)};

        // Empty-list corner cases
        queue_item(MODE_DEL_HEAD,  32'd3, 32'd0);
        queue_item(MODE_DEL_TAIL,  32'd3, 32'd0);
        queue_item(MODE_DEL_VALUE, VMAX,  VMIN);
        queue_item(MODE_SEARCH,    VMIN,  VMAX);
        queue_item(MODE_INS_AFTER, 32'd4, VMAX);
        queue_item(MODE_COUNT,     VMIN,  VMAX);
        // Build [MAX, -1, MIN, 0, MAX, 5]; the last insert-after hits the tail
        // although the anchor also sits at the head
        queue_item(MODE_INS_TAIL,  VMIN,         32'd0);
        queue_item(MODE_INS_HEAD,  VMAX,         32'hffff_ffff);
        queue_item(MODE_INS_TAIL,  32'd0,        VMIN);
        queue_item(MODE_INS_AFTER, 32'hffff_ffff, VMAX);
        queue_item(MODE_INS_TAIL,  VMAX,         32'd0);
        queue_item(MODE_INS_AFTER, 32'd5,        VMAX);
        // Lookups: head hit, tail hit, misses
        queue_item(MODE_SEARCH,    VMAX,   32'd0);
        queue_item(MODE_SEARCH,    32'd5,  32'd0);
        queue_item(MODE_SEARCH,    32'd7,  32'd0);
        queue_item(MODE_INS_AFTER, 32'd9,  32'd123);
        queue_item(MODE_DEL_VALUE, 32'd77, 32'd0);
        // Deletes: tail match, head match, head, tail
        queue_item(MODE_DEL_VALUE, 32'd5,  32'd0);
        queue_item(MODE_DEL_VALUE, VMAX,   32'd0);
        queue_item(MODE_DEL_HEAD,  32'd0,  32'd0);
        queue_item(MODE_DEL_TAIL,  32'd0,  32'd0);
        queue_item(MODE_COUNT,     VMAX,   VMIN);
        queue_item(MODE_INS_AFTER, VMAX,   VMIN);

        // Random episodes: fill runs push the list to full, drain runs empty it,
        // the rest mix operations on values that mostly hit
        first_drain = 1'b1;
        while (request_q.size() < TOTAL_ITEMS) begin
            kind = $urandom_range(0, 3);
            n    = $urandom_range(8, 22);
            for (int k = 0; k < n && request_q.size() < TOTAL_ITEMS; k++) begin
                case (kind)
                    0: begin
                        if ($urandom_range(0, 4) == 0) m = MODE_INS_AFTER;
                        else if ($urandom_range(0, 1) == 0) m = MODE_INS_HEAD;
                        else m = MODE_INS_TAIL;
                    end
                    1: m = t_mode'($urandom_range(MODE_DEL_HEAD, MODE_SEARCH));
                    2: m = t_mode'($urandom_range(0, 7));
                    default: begin
                        case ($urandom_range(0, 2))
                            0:       m = MODE_INS_AFTER;
                            1:       m = MODE_DEL_VALUE;
                            default: m = MODE_SEARCH;
                        endcase
                    end
                endcase
                // no drain pauses in the calm tail of the run
                queue_item(m, pick_value(), pick_value(),
                           k == 0 && request_q.size() < TOTAL_ITEMS - CALM_ITEMS &&
                           (first_drain || $urandom_range(0, 7) == 0));
                first_drain = 1'b0;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (request_q.size() != 0 || req_bus.valid || reply_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
